### hdl/ils_pkg.sv
// shared types and constants for the integer list sorter
package ils_pkg;

    localparam int VALUE_W = 32;

    // one storage slot of the sorting row
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } t_slot;

    // row-wide control broadcast to every cell
    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctl;

endpackage

### hdl/ils_cell.sv
// one cell of the insertion sorting row: holds one slot, compares and shifts
module ils_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ils_pkg::t_cell_ctl               i_ctl,
    input  logic [ils_pkg::VALUE_W-1:0]      i_new_value,
    input  ils_pkg::t_slot                   i_left,
    input  logic                             i_left_gt,
    input  ils_pkg::t_slot                   i_right,
    output ils_pkg::t_slot                   o_slot,
    output logic                             o_gt
);

    logic                        r_valid;
    logic [ils_pkg::VALUE_W-1:0] r_value;
    logic                        n_valid;
    logic [ils_pkg::VALUE_W-1:0] n_value;

    // an empty cell acts as plus infinity
    assign o_gt = !r_valid || ($signed(r_value) > $signed(i_new_value));

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctl.pop) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end else if (i_ctl.insert && o_gt) begin
            if (i_left_gt) begin
                // make room: take the neighbor's value
                n_valid = i_left.valid;
                n_value = i_left.value;
            end else begin
                n_valid = 1'b1;
                n_value = i_new_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_slot.valid = r_valid;
    assign o_slot.value = r_value;

endmodule

### hdl/integer_list_sorter_core.sv
// Integer list sorter: a row of CAPACITY cells keeps the list sorted as it
// arrives. While loading, one request is accepted every cycle; each new value
// is compared against every cell at once and the larger entries shift one
// cell to the right. Values beyond CAPACITY are dropped and flag overflow on
// every result of that list. The first result appears the cycle after the
// request marked last, then results leave the head cell at one per cycle as
// the row shifts left, stalling while i_ready is low.
// Input ready is low while a list is being emitted.
module integer_list_sorter_core #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [31:0]          i_value_in,
    input  logic                        i_last_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [31:0]          o_value_out,
    output logic                        o_last_out,
    output logic                        o_overflow
);

    ils_pkg::t_slot     w_slot [CAPACITY];
    logic [CAPACITY-1:0] w_gt;
    logic [CAPACITY-1:0] w_valid;
    ils_pkg::t_cell_ctl w_ctl;

    logic r_drain;
    logic r_dropped;
    logic n_drain;
    logic n_dropped;

    logic w_in_req;
    logic w_out_req;
    logic w_full;

    assign w_in_req  = i_valid && o_ready;
    assign w_out_req = o_valid && i_ready;
    assign w_full    = w_slot[CAPACITY-1].valid;

    assign w_ctl.insert = w_in_req && !w_full;
    assign w_ctl.pop    = w_out_req;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            ils_pkg::t_slot w_left;
            ils_pkg::t_slot w_right;
            logic           w_left_gt;

            if (g == 0) begin : g_head
                assign w_left    = '0;
                assign w_left_gt = 1'b0;
            end else begin : g_mid
                assign w_left    = w_slot[g-1];
                assign w_left_gt = w_gt[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_body
                assign w_right = w_slot[g+1];
            end

            ils_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_new_value (i_value_in),
                .i_left      (w_left),
                .i_left_gt   (w_left_gt),
                .i_right     (w_right),
                .o_slot      (w_slot[g]),
                .o_gt        (w_gt[g])
            );

            assign w_valid[g] = w_slot[g].valid;
        end
    endgenerate

    always_comb begin
        n_drain   = r_drain;
        n_dropped = r_dropped;
        if (w_in_req) begin
            if (w_full) begin
                n_dropped = 1'b1;
            end
            if (i_last_in) begin
                n_drain = 1'b1;
            end
        end
        if (w_out_req && o_last_out) begin
            n_drain   = 1'b0;
            n_dropped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain   <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            r_drain   <= n_drain;
            r_dropped <= n_dropped;
        end
    end

    assign o_ready     = !r_drain;
    assign o_valid     = r_drain;
    assign o_value_out = $signed(w_slot[0].value);
    assign o_last_out  = !w_slot[1].valid;
    assign o_overflow  = r_dropped;

    // occupied cells always form a prefix of the row
    logic w_gap;
    assign w_gap = |(w_valid[CAPACITY-1:1] & ~w_valid[CAPACITY-2:0]);

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> w_slot[0].valid)
        else $error("result offered from an empty head cell");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_gap)
        else $error("hole in the occupied cells");

    a_end_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_req && o_last_out) |=> (!r_drain && !r_dropped && !w_slot[0].valid))
        else $error("row not empty after final result");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_dropped) |-> w_full)
        else $error("overflow flagged with free cells");

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drain && w_slot[1].valid) |->
            ($signed(w_slot[0].value) <= $signed(w_slot[1].value)))
        else $error("head cells out of order");

endmodule
